FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/robs_pkg.sv
package robs_pkg;

  localparam int unsigned LW       = 16;
  localparam int unsigned NL       = 3;
  localparam int unsigned VW       = LW * NL;
  localparam int unsigned DIN_W    = 336;
  localparam int unsigned DOUT_W   = 168;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned TOL_W    = 14;
  localparam logic [TOL_W-1:0] TOL_RESET = 14'd1;
  localparam logic REG_TOL = 1'b0;

  // e, f, half and numerator widths
  localparam int unsigned EW       = 35;
  localparam int unsigned FW       = 34;
  localparam int unsigned HW       = 30;
  localparam int unsigned NUMW     = 36;
  localparam int unsigned FRAC_SH  = 22;
  localparam int unsigned DVS_W    = 32;
  localparam int unsigned MAG_W    = 34;
  localparam int unsigned DVD_W    = MAG_W + FRAC_SH;
  localparam int unsigned DIV_N    = DVD_W;
  localparam int unsigned TW       = DVD_W + 2;
  localparam int unsigned TSW      = 32;
  localparam int unsigned LANE_LAT = DIV_N + 3;

  // Unbounded interval ends, outside the range of any real crossing
  localparam logic signed [TW-1:0] T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_POS_INF = {1'b0, {(TW-1){1'b1}}};

  typedef struct packed {
    logic signed [TW-1:0] lo;
    logic signed [TW-1:0] hi;
    logic                 outside;
  } lane_res_t;

  typedef struct packed {
    logic                  hit;
    logic [1:0]            hit_count;
    logic signed [TSW-1:0] t_first;
    logic signed [TSW-1:0] t_second;
    logic [VW-1:0]         point_first;
    logic [VW-1:0]         point_second;
  } result_t;

endpackage

FILE: hw/rtl/robs_div.sv
// Pipelined restoring divider: one quotient bit per stage, sign applied at the end.
module robs_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [robs_pkg::DVD_W-1:0]         dvd_i,
  input  logic [robs_pkg::DVS_W-1:0]         dvs_i,
  input  logic                               neg_i,
  output logic signed [robs_pkg::TW-1:0]     q_o
);

  logic [robs_pkg::DVS_W-1:0] rem_q [robs_pkg::DIV_N];
  logic [robs_pkg::DVD_W-1:0] dvd_q [robs_pkg::DIV_N];
  logic [robs_pkg::DVS_W-1:0] dvs_q [robs_pkg::DIV_N];
  logic                       neg_q [robs_pkg::DIV_N];

  for (genvar k = 0; k < robs_pkg::DIV_N; k++) begin : g_stage
    logic [robs_pkg::DVS_W-1:0] r_in;
    logic [robs_pkg::DVD_W-1:0] d_in;
    logic [robs_pkg::DVS_W-1:0] s_in;
    logic                       n_in;
    logic [robs_pkg::DVS_W:0]   trial;
    logic [robs_pkg::DVS_W:0]   diff;
    logic                       ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign d_in = dvd_i;
      assign s_in = dvs_i;
      assign n_in = neg_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = dvd_q[k-1];
      assign s_in = dvs_q[k-1];
      assign n_in = neg_q[k-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {r_in, d_in[robs_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, s_in};
    assign ge    = (trial >= {1'b0, s_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[robs_pkg::DVS_W-1:0] : trial[robs_pkg::DVS_W-1:0];
        dvd_q[k] <= {d_in[robs_pkg::DVD_W-2:0], ge};
        dvs_q[k] <= s_in;
        neg_q[k] <= n_in;
      end
    end
  end

  // apply the quotient sign (truncation toward zero)
  logic signed [robs_pkg::TW-1:0] mag;
  assign mag = $signed({2'b00, dvd_q[robs_pkg::DIV_N-1]});
  assign q_o = neg_q[robs_pkg::DIV_N-1] ? -mag : mag;

endmodule

FILE: hw/rtl/robs_lane.sv
// One box axis: projections, both slab crossings and their ordering.
module robs_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [robs_pkg::VW-1:0]       axis_i,
  input  logic [robs_pkg::VW-1:0]       org_i,
  input  logic [robs_pkg::VW-1:0]       dir_i,
  input  logic [robs_pkg::VW-1:0]       ctr_i,
  input  logic [robs_pkg::LW-1:0]       half_i,
  input  logic [robs_pkg::TOL_W-1:0]    tol_i,
  output robs_pkg::lane_res_t           res_o
);

  // Stage A: per-component products
  logic signed [32:0]               pe_q [robs_pkg::NL];
  logic signed [31:0]               pf_q [robs_pkg::NL];
  logic signed [robs_pkg::LW-1:0]   h_q;
  logic [robs_pkg::TOL_W-1:0]       tol_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < robs_pkg::NL; k++) begin
        pe_q[k] <= $signed(axis_i[16*k +: 16]) *
                   ($signed({ctr_i[16*k+15], ctr_i[16*k +: 16]}) -
                    $signed({org_i[16*k+15], org_i[16*k +: 16]}));
        pf_q[k] <= $signed(axis_i[16*k +: 16]) * $signed(dir_i[16*k +: 16]);
      end
      h_q   <= $signed(half_i);
      tol_q <= tol_i;
    end
  end

  // Stage B: sums, numerators, magnitudes and slab flags
  logic signed [robs_pkg::EW-1:0]   e_s;
  logic signed [robs_pkg::FW-1:0]   f_s;
  logic signed [robs_pkg::HW-1:0]   h_s;
  logic signed [robs_pkg::NUMW-1:0] nump, numm, absp, absm;
  logic [robs_pkg::FW-1:0]          absf;

  assign e_s  = robs_pkg::EW'(pe_q[0]) + robs_pkg::EW'(pe_q[1]) + robs_pkg::EW'(pe_q[2]);
  assign f_s  = robs_pkg::FW'(pf_q[0]) + robs_pkg::FW'(pf_q[1]) + robs_pkg::FW'(pf_q[2]);
  assign h_s  = robs_pkg::HW'(h_q) <<< 14;
  assign nump = robs_pkg::NUMW'(e_s) + robs_pkg::NUMW'(h_s);
  assign numm = robs_pkg::NUMW'(e_s) - robs_pkg::NUMW'(h_s);
  assign absp = nump[robs_pkg::NUMW-1] ? -nump : nump;
  assign absm = numm[robs_pkg::NUMW-1] ? -numm : numm;
  assign absf = f_s[robs_pkg::FW-1] ? robs_pkg::FW'(-f_s) : robs_pkg::FW'(f_s);

  logic [robs_pkg::DVD_W-1:0] dvdp_q, dvdm_q;
  logic [robs_pkg::DVS_W-1:0] dvs_q;
  logic                       negp_q, negm_q, np_q, out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvdp_q <= {absp[robs_pkg::MAG_W-1:0], {robs_pkg::FRAC_SH{1'b0}}};
      dvdm_q <= {absm[robs_pkg::MAG_W-1:0], {robs_pkg::FRAC_SH{1'b0}}};
      dvs_q  <= absf[robs_pkg::DVS_W-1:0];
      negp_q <= nump[robs_pkg::NUMW-1] ^ f_s[robs_pkg::FW-1];
      negm_q <= numm[robs_pkg::NUMW-1] ^ f_s[robs_pkg::FW-1];
      np_q   <= (absf > {6'd0, tol_q, 14'd0});
      out_q  <= nump[robs_pkg::NUMW-1] || (numm > 0);
    end
  end

  // Divide both crossings
  logic signed [robs_pkg::TW-1:0] q1, q2;

  robs_div u_div_p (
    .clk_i (clk_i), .en_i (en_i), .dvd_i (dvdp_q), .dvs_i (dvs_q),
    .neg_i (negp_q), .q_o (q1)
  );

  robs_div u_div_m (
    .clk_i (clk_i), .en_i (en_i), .dvd_i (dvdm_q), .dvs_i (dvs_q),
    .neg_i (negm_q), .q_o (q2)
  );

  // Hold slab flags alongside the divider
  logic np_dly_q  [robs_pkg::DIV_N];
  logic out_dly_q [robs_pkg::DIV_N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      np_dly_q[0]  <= np_q;
      out_dly_q[0] <= out_q;
      for (int k = 1; k < robs_pkg::DIV_N; k++) begin
        np_dly_q[k]  <= np_dly_q[k-1];
        out_dly_q[k] <= out_dly_q[k-1];
      end
    end
  end

  // Order the crossings; a parallel axis leaves the interval unbounded
  logic np_l;
  assign np_l = np_dly_q[robs_pkg::DIV_N-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (np_l) begin
        res_o.lo <= (q1 > q2) ? q2 : q1;
        res_o.hi <= (q1 > q2) ? q1 : q2;
      end else begin
        res_o.lo <= robs_pkg::T_NEG_INF;
        res_o.hi <= robs_pkg::T_POS_INF;
      end
      res_o.outside <= !np_l && out_dly_q[robs_pkg::DIV_N-1];
    end
  end

endmodule

FILE: hw/rtl/robs_merge.sv
// Combine the three lanes into an interval, then form hits and hit points.
module robs_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  robs_pkg::lane_res_t       lane_i [robs_pkg::NL],
  input  logic [robs_pkg::VW-1:0]   org_i,
  input  logic [robs_pkg::VW-1:0]   dir_i,
  output logic                      vld_o,
  output robs_pkg::result_t         res_o
);

  function automatic logic signed [robs_pkg::TSW-1:0] sat_t(
      input logic signed [robs_pkg::TW-1:0] t);
    logic signed [robs_pkg::TSW-1:0] r;
    if (t > robs_pkg::TW'(32'sh7FFFFFFF))      r = 32'sh7FFFFFFF;
    else if (t < -(robs_pkg::TW'(33'sh080000000))) r = 32'sh80000000;
    else                                       r = t[robs_pkg::TSW-1:0];
    return r;
  endfunction

  function automatic logic [robs_pkg::LW-1:0] pt_lane(
      input logic signed [47:0] prod, input logic signed [robs_pkg::LW-1:0] o);
    logic signed [48:0] rnd;
    logic signed [26:0] stp;
    logic signed [27:0] v;
    logic [robs_pkg::LW-1:0] r;
    rnd = 49'(prod) + 49'sd2097152;
    stp = 27'(rnd >>> 22);
    v   = 28'(stp) + 28'(o);
    if (v > 28'sd32767)       r = 16'h7FFF;
    else if (v < -28'sd32768) r = 16'h8000;
    else                      r = v[robs_pkg::LW-1:0];
    return r;
  endfunction

  // M1: narrow the interval
  logic signed [robs_pkg::TW-1:0] lo0, lo1, lo2, hi0, hi1, hi2, mx01, mn01;
  logic signed [robs_pkg::TW-1:0] tmin_q, tmax_q;
  logic                           outside_q, v1_q;
  logic [robs_pkg::VW-1:0]        org1_q, dir1_q;

  assign lo0  = lane_i[0].lo;
  assign lo1  = lane_i[1].lo;
  assign lo2  = lane_i[2].lo;
  assign hi0  = lane_i[0].hi;
  assign hi1  = lane_i[1].hi;
  assign hi2  = lane_i[2].hi;
  assign mx01 = (lo0 > lo1) ? lo0 : lo1;
  assign mn01 = (hi0 < hi1) ? hi0 : hi1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmin_q    <= (mx01 > lo2) ? mx01 : lo2;
      tmax_q    <= (mn01 < hi2) ? mn01 : hi2;
      outside_q <= lane_i[0].outside || lane_i[1].outside || lane_i[2].outside;
      org1_q    <= org_i;
      dir1_q    <= dir_i;
    end
  end

  // M2: reject, saturate
  logic                            rej;
  logic                            h1_q, h2_q, v2_q;
  logic signed [robs_pkg::TSW-1:0] smin_q, smax_q;
  logic [robs_pkg::VW-1:0]         org2_q, dir2_q;

  assign rej = outside_q || (tmin_q > tmax_q) || (tmax_q < 0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q   <= !rej && (tmin_q > 0);
      h2_q   <= !rej && (tmax_q > 0);
      smin_q <= sat_t(tmin_q);
      smax_q <= sat_t(tmax_q);
      org2_q <= org1_q;
      dir2_q <= dir1_q;
    end
  end

  // M3: pick result slots, multiply by direction
  logic signed [robs_pkg::TSW-1:0] t1, t2, t1_q, t2_q;
  logic signed [47:0]              p1_q [robs_pkg::NL];
  logic signed [47:0]              p2_q [robs_pkg::NL];
  logic [1:0]                      cnt_q;
  logic                            v3_q;
  logic [robs_pkg::VW-1:0]         org3_q;

  assign t1 = h1_q ? smin_q : (h2_q ? smax_q : '0);
  assign t2 = (h1_q && h2_q) ? smax_q : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t1;
      t2_q   <= t2;
      cnt_q  <= {1'b0, h1_q} + {1'b0, h2_q};
      org3_q <= org2_q;
      for (int k = 0; k < robs_pkg::NL; k++) begin
        p1_q[k] <= t1 * $signed(dir2_q[16*k +: 16]);
        p2_q[k] <= t2 * $signed(dir2_q[16*k +: 16]);
      end
    end
  end

  // M4: round, add origin, saturate into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.hit       <= (cnt_q != 2'd0);
      res_o.hit_count <= cnt_q;
      res_o.t_first   <= t1_q;
      res_o.t_second  <= t2_q;
      for (int k = 0; k < robs_pkg::NL; k++) begin
        res_o.point_first[16*k +: 16]  <= (cnt_q != 2'd0) ?
            pt_lane(p1_q[k], $signed(org3_q[16*k +: 16])) : '0;
        res_o.point_second[16*k +: 16] <= (cnt_q == 2'd2) ?
            pt_lane(p2_q[k], $signed(org3_q[16*k +: 16])) : '0;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      v1_q  <= vld_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      vld_o <= v3_q;
    end
  end

endmodule

FILE: hw/rtl/ray_obb_slab_intersect.sv
// Ray versus oriented box test by the slab method, one ray and box per input
// word and exactly one result word per input. A new word is taken every cycle
// unless the pipeline stalls; each word passes through 2 projection stages, a 56-stage
// bit-per-cycle divider per slab crossing, 1 ordering stage and 4 merge
// stages. The whole pipeline advances together and stalls only while a
// result waits in the output register. Three axis lanes work in parallel.
// parallel_tolerance sits at byte address 0 and must be written while idle.
module ray_obb_slab_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [robs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // ray_origin, ray_direction, box_center, box_axis_zero, box_axis_one,
  // box_axis_two, box_half_sizes (48 bits each, from bit 0 up)
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [robs_pkg::DIN_W-1:0]    s_axis_tdata,
  // hit, hit_count[2], t_first[32], t_second[32], point_first[48],
  // point_second[48], zero pad[5] (from bit 0 up)
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [robs_pkg::DOUT_W-1:0]   m_axis_tdata
);

  // Configuration register
  logic [robs_pkg::TOL_W-1:0] tol_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == robs_pkg::REG_TOL) ? {18'd0, tol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= robs_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && paddr[2] == robs_pkg::REG_TOL) begin
      tol_q <= pwdata[robs_pkg::TOL_W-1:0];
    end
  end

  // Pipeline advance
  logic en, out_vld;
  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  logic [robs_pkg::VW-1:0] org, dir, ctr, half;
  assign org  = s_axis_tdata[0   +: 48];
  assign dir  = s_axis_tdata[48  +: 48];
  assign ctr  = s_axis_tdata[96  +: 48];
  assign half = s_axis_tdata[288 +: 48];

  // Axis lanes
  robs_pkg::lane_res_t lane_res [robs_pkg::NL];

  for (genvar i = 0; i < robs_pkg::NL; i++) begin : g_lane
    robs_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .axis_i (s_axis_tdata[144 + 48*i +: 48]),
      .org_i  (org),
      .dir_i  (dir),
      .ctr_i  (ctr),
      .half_i (half[16*i +: 16]),
      .tol_i  (tol_q),
      .res_o  (lane_res[i])
    );
  end

  // Carry valid, origin and direction past the lanes
  logic                    vld_dly_q [robs_pkg::LANE_LAT];
  logic [robs_pkg::VW-1:0] org_dly_q [robs_pkg::LANE_LAT];
  logic [robs_pkg::VW-1:0] dir_dly_q [robs_pkg::LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < robs_pkg::LANE_LAT; k++) vld_dly_q[k] <= 1'b0;
    end else if (en) begin
      vld_dly_q[0] <= s_axis_tvalid;
      for (int k = 1; k < robs_pkg::LANE_LAT; k++) vld_dly_q[k] <= vld_dly_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      org_dly_q[0] <= org;
      dir_dly_q[0] <= dir;
      for (int k = 1; k < robs_pkg::LANE_LAT; k++) begin
        org_dly_q[k] <= org_dly_q[k-1];
        dir_dly_q[k] <= dir_dly_q[k-1];
      end
    end
  end

  // Merge and output register
  robs_pkg::result_t res;

  robs_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_dly_q[robs_pkg::LANE_LAT-1]),
    .lane_i (lane_res),
    .org_i  (org_dly_q[robs_pkg::LANE_LAT-1]),
    .dir_i  (dir_dly_q[robs_pkg::LANE_LAT-1]),
    .vld_o  (out_vld),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {5'd0, res.point_second, res.point_first, res.t_second,
                          res.t_first, res.hit_count, res.hit};

  // Checks
  `include "assert_macros.svh"

  `ASSERT_IMP(a_hit_matches_count, clk_i, rst_ni, m_axis_tvalid,
              m_axis_tdata[0] == (m_axis_tdata[2:1] != 2'd0))
  `ASSERT_IMP(a_count_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[2:1] != 2'd3)
  `ASSERT_IMP(a_second_slot_clear, clk_i, rst_ni,
              m_axis_tvalid && m_axis_tdata[2:1] != 2'd2, m_axis_tdata[66:35] == 32'd0)
  `ASSERT_NXT(a_stall_freezes_input, clk_i, rst_ni,
              out_vld && !m_axis_tready, s_axis_tready == m_axis_tready || out_vld)

endmodule

FILE: test/ray_obb_checker.sv
`timescale 1ns / 1ps

module ray_obb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [robs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [robs_pkg::DIN_W-1:0]    s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [robs_pkg::DOUT_W-1:0]   m_axis_tdata,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            hits_seen_o
);

  localparam logic [robs_pkg::ADDR_W-1:0] TOL_ADDR =
      robs_pkg::ADDR_W'(robs_pkg::REG_TOL) << 2;
  localparam longint T_LO = 64'sh8000_0000_0000_0000;
  localparam longint T_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint T32_MIN = -64'sd2147483648;
  localparam longint T32_MAX = 64'sd2147483647;

  logic [robs_pkg::TOL_W-1:0] tol_q;
  robs_pkg::result_t          slab_results_q[$];

  function automatic longint lane_of(logic [robs_pkg::VW-1:0] v, int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // origin + t * direction, rounded half up to Q8.8 and saturated per lane
  function automatic logic [robs_pkg::VW-1:0] ray_point(longint t,
                                                        logic [robs_pkg::VW-1:0] org,
                                                        logic [robs_pkg::VW-1:0] dir);
    logic [robs_pkg::VW-1:0] p;
    longint                  st;
    p = '0;
    for (int k = 0; k < 3; k++) begin
      st = (t * lane_of(dir, k) + (64'sd1 <<< 21)) >>> 22;
      p[16*k +: 16] = 16'(sat(st + lane_of(org, k), -32768, 32767));
    end
    return p;
  endfunction

  function automatic robs_pkg::result_t slab_test(logic [robs_pkg::DIN_W-1:0] d,
                                                  logic [robs_pkg::TOL_W-1:0] tol);
    robs_pkg::result_t       r;
    logic [robs_pkg::VW-1:0] org, dir, ctr, half, ax;
    longint                  tmin, tmax, tolv, e, f, h, t1, t2, s, ts[2];
    logic [robs_pkg::VW-1:0] ps[2];
    bit                      rej;
    int                      cnt;
    org = d[0 +: robs_pkg::VW];
    dir = d[robs_pkg::VW +: robs_pkg::VW];
    ctr = d[2*robs_pkg::VW +: robs_pkg::VW];
    half = d[6*robs_pkg::VW +: robs_pkg::VW];
    tmin = T_LO; tmax = T_HI; tolv = longint'(tol) * 16384;
    rej = 0; cnt = 0; ts[0] = 0; ts[1] = 0; ps[0] = '0; ps[1] = '0;
    for (int i = 0; i < 3 && !rej; i++) begin
      ax = d[(3+i)*robs_pkg::VW +: robs_pkg::VW];
      e = 0; f = 0;
      for (int k = 0; k < 3; k++) begin
        e += lane_of(ax, k) * (lane_of(ctr, k) - lane_of(org, k));
        f += lane_of(ax, k) * lane_of(dir, k);
      end
      h = lane_of(half, i) * 16384;
      if ((f < 0 ? -f : f) > tolv) begin
        // slab crossings, truncated toward zero
        t1 = ((e + h) * 4194304) / f;
        t2 = ((e - h) * 4194304) / f;
        if (t1 > t2) begin s = t1; t1 = t2; t2 = s; end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax || tmax < 0) rej = 1;
      end else if (e + h < 0 || e - h > 0) begin
        rej = 1;
      end
    end
    if (!rej) begin
      if (tmin > 0) begin
        ts[cnt] = sat(tmin, T32_MIN, T32_MAX);
        ps[cnt] = ray_point(ts[cnt], org, dir);
        cnt++;
      end
      if (tmax > 0) begin
        ts[cnt] = sat(tmax, T32_MIN, T32_MAX);
        ps[cnt] = ray_point(ts[cnt], org, dir);
        cnt++;
      end
    end
    r.hit = (cnt != 0);
    r.hit_count = 2'(cnt);
    r.t_first = 32'(ts[0]);
    r.t_second = 32'(ts[1]);
    r.point_first = ps[0];
    r.point_second = ps[1];
    return r;
  endfunction

  function automatic robs_pkg::result_t unpack_word(logic [robs_pkg::DOUT_W-1:0] w);
    robs_pkg::result_t r;
    r.hit = w[0];
    r.hit_count = w[2:1];
    r.t_first = w[34:3];
    r.t_second = w[66:35];
    r.point_first = w[114:67];
    r.point_second = w[162:115];
    return r;
  endfunction

  assign pending_o = slab_results_q.size();

  // track the tolerance, predict on input words, compare output words
  always @(posedge clk_i or negedge rst_ni) begin
    robs_pkg::result_t got, want;
    if (!rst_ni) begin
      tol_q <= robs_pkg::TOL_RESET;
      slab_results_q.delete();
      fail_count_o <= 0;
      checked_o <= 0;
      hits_seen_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == TOL_ADDR)
        tol_q <= pwdata[robs_pkg::TOL_W-1:0];
      if (s_axis_tvalid && s_axis_tready)
        slab_results_q.push_back(slab_test(s_axis_tdata, tol_q));
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_word(m_axis_tdata);
        checked_o <= checked_o + 1;
        if (got.hit) hits_seen_o <= hits_seen_o + 1;
        if (slab_results_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("ERROR: unexpected output word %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = slab_results_q.pop_front();
          if (got !== want || m_axis_tdata[robs_pkg::DOUT_W-1:163] !== '0) begin
            if (fail_count_o < 10) begin
              $display("ERROR: result %0d mismatch", checked_o);
              $display("  exp hit=%b cnt=%0d t=%h/%h p=%h/%h", want.hit, want.hit_count,
                       want.t_first, want.t_second, want.point_first, want.point_second);
              $display("  got hit=%b cnt=%0d t=%h/%h p=%h/%h", got.hit, got.hit_count,
                       got.t_first, got.t_second, got.point_first, got.point_second);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [robs_pkg::ADDR_W-1:0] TOL_ADDR =
      robs_pkg::ADDR_W'(robs_pkg::REG_TOL) << 2;
  localparam logic [15:0] ONE_Q14 = 16'h4000;
  localparam int RANDOM_ITEMS = 440;
  localparam int DRAIN_CYCLES = 100;

  logic                          clk_i = 0;
  logic                          rst_ni = 0;
  logic                          psel = 0, penable = 0, pwrite = 0;
  logic [robs_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          s_axis_tvalid = 0;
  logic                          s_axis_tready;
  logic [robs_pkg::DIN_W-1:0]    s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 0;
  logic [robs_pkg::DOUT_W-1:0]   m_axis_tdata;
  int                            fail_count, pending, checked, hits_seen;
  bit                            no_idle = 0;
  int                            sink_hold = 0;

  ray_obb_slab_intersect dut (.*);

  ray_obb_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .hits_seen_o(hits_seen)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

  // stall the output side in bursts
  always @(posedge clk_i) begin
    if (no_idle) begin
      m_axis_tready <= 1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 0;
      sink_hold <= $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1;
    end
  end

  task automatic apb_write(logic [robs_pkg::ADDR_W-1:0] a, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // wait until every predicted result is out and the pipeline is empty
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // called at a rising edge; returns at the edge that accepts the word, or after a random idle gap that follows it
  task automatic send_word(logic [robs_pkg::DIN_W-1:0] d);
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [robs_pkg::VW-1:0] vec(logic [15:0] x, logic [15:0] y,
                                                  logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [robs_pkg::DIN_W-1:0] ray_box(logic [robs_pkg::VW-1:0] org,
                                                         logic [robs_pkg::VW-1:0] dir,
                                                         logic [robs_pkg::VW-1:0] ctr,
                                                         logic [robs_pkg::VW-1:0] half);
    return {half, vec('0, '0, ONE_Q14), vec('0, ONE_Q14, '0), vec(ONE_Q14, '0, '0),
            ctr, dir, org};
  endfunction

  // well-formed box: signed permuted unit axes, nearby ray
  function automatic logic [robs_pkg::DIN_W-1:0] shaped_item();
    logic [robs_pkg::VW-1:0] ax[3], org, ctr, half, dir;
    logic [15:0]             u;
    int                      p, q;
    p = $urandom_range(0, 2);
    q = $urandom_range(1, 2);
    for (int i = 0; i < 3; i++) begin
      u = $urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14;
      ax[i] = '0;
      ax[i][16*((p + i * q) % 3) +: 16] = u;
    end
    for (int k = 0; k < 3; k++) begin
      org[16*k +: 16] = 16'($signed($urandom_range(0, 4096)) - 2048);
      ctr[16*k +: 16] = 16'($signed($urandom_range(0, 2048)) - 1024);
      half[16*k +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                         16'($urandom_range(1, 1024));
      dir[16*k +: 16] = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 3)) :
                        16'($urandom);
    end
    return {half, ax[2], ax[1], ax[0], ctr, dir, org};
  endfunction

  function automatic logic [robs_pkg::DIN_W-1:0] noise_item();
    logic [robs_pkg::DIN_W-1:0] d;
    for (int i = 0; i < robs_pkg::DIN_W / 16; i++) d[16*i +: 16] = 16'($urandom);
    return d;
  endfunction

  initial begin
    logic [robs_pkg::VW-1:0] unit_x;
    int                      tols[4];
    unit_x = vec(ONE_Q14, '0, '0);
    tols = '{0, 16383, 100, 1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;

    // corners and special cases at the reset tolerance
    send_word('0);
    send_word('1);
    // parallel ray inside every slab: unbounded exit
    send_word(ray_box('0, '0, '0, vec(16'h0100, 16'h0100, 16'h0100)));
    // parallel ray outside a slab
    send_word(ray_box(vec(16'h0800, '0, '0), vec('0, ONE_Q14, '0), '0,
                      vec(16'h0100, 16'h0100, 16'h0100)));
    // box ahead, box behind, origin inside
    send_word(ray_box(vec(16'hF800, '0, '0), unit_x, '0,
                      vec(16'h0100, 16'h0100, 16'h0100)));
    send_word(ray_box(vec(16'h0800, '0, '0), unit_x, '0,
                      vec(16'h0100, 16'h0100, 16'h0100)));
    send_word(ray_box('0, unit_x, '0, vec(16'h0100, 16'h0100, 16'h0100)));
    // negative half sizes
    send_word(ray_box(vec(16'hF800, '0, '0), unit_x, '0,
                      vec(16'hFF00, 16'hFF00, 16'hFF00)));
    // crossing near 2^-15
    send_word(ray_box(vec(16'hFF00, '0, '0), vec(16'h7FFF, '0, '0), vec(16'h0000, '0, '0),
                      vec(16'h00FF, 16'h0100, 16'h0100)));
    // lane extremes: t saturates, points saturate
    send_word(ray_box(vec(16'h8000, 16'h7FFF, 16'h8000), vec(16'h0001, 16'h7FFF, 16'h8000),
                      vec(16'h7FFF, 16'h8000, 16'h7FFF), vec(16'h7FFF, 16'h7FFF, 16'h7FFF)));
    send_word(ray_box(vec(16'h7FFF, '0, '0), vec(16'h0002, 16'h7FFF, '0),
                      vec(16'h8000, '0, '0), vec(16'h7FFF, 16'h7FFF, 16'h7FFF)));
    s_axis_tvalid <= 0;
    drain();

    // random words under each tolerance, the second half of the last phase with no idling
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(TOL_ADDR, tols[ph]);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if (ph == 3 && n >= RANDOM_ITEMS / 8) no_idle = 1;
        send_word($urandom_range(0, 9) < 7 ? shaped_item() : noise_item());
      end
      s_axis_tvalid <= 0;
      drain();
    end

    $display("Checked %0d results (%0d hits) over tolerances 1, 0, 16383, 100 and 1.",
             checked, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
